/* hw/rtl/rclbh_pkg.sv */
// Shared types and constants for the receiver control core.
// No dependencies; imported by every other file in this folder but rclbh_if.
package rclbh_pkg;

  localparam int HOP_CHANNELS   = 20;
  localparam int ADDRESS_BYTES  = 5;
  localparam int SERVO_CHANNELS = 3;
  localparam int STORE_BYTES    = ADDRESS_BYTES + HOP_CHANNELS;
  localparam int STORE_W        = $clog2(STORE_BYTES);
  localparam int HOP_W          = $clog2(HOP_CHANNELS);
  localparam int PKT_BYTES      = 10;
  localparam int HOP_PER_PKT    = 7;

  localparam logic [7:0] PAIR_CHAN    = 8'h51;
  localparam logic [7:0] HDR_B0       = 8'hff;
  localparam logic [7:0] HDR_B1       = 8'haa;
  localparam logic [7:0] HDR_B2       = 8'h55;
  localparam logic [7:0] TAG_STICK    = 8'h55;
  localparam logic [7:0] TAG_FAILSAFE = 8'haa;
  localparam logic [7:0] TAG_FS_TAKE  = 8'h5a;

  // event modes
  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_HOP     = 3'd1;
  localparam logic [2:0] MODE_PACKET  = 3'd2;
  localparam logic [2:0] MODE_BIND    = 3'd3;
  localparam logic [2:0] MODE_RESTORE = 3'd4;

  // link status
  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_RECEIVE  = 2'd1;
  localparam logic [1:0] ST_FAILSAFE = 2'd2;
  localparam logic [1:0] ST_BIND     = 2'd3;

  // hop timer commands
  localparam logic [1:0] HOP_NONE    = 2'd0;
  localparam logic [1:0] HOP_RESTART = 2'd1;
  localparam logic [1:0] HOP_STOP    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_FAILSAFE_TICKS = 2'd0;
  localparam logic [1:0] CFG_BIND_TICKS     = 2'd1;
  localparam logic [1:0] CFG_SERVO_CENTER   = 2'd2;
  localparam logic [1:0] CFG_MAX_MISSED     = 2'd3;

  localparam logic [15:0] RST_FAILSAFE_TICKS = 16'd64;
  localparam logic [15:0] RST_BIND_TICKS     = 16'd500;
  localparam logic [15:0] RST_SERVO_CENTER   = 16'd1500;
  localparam logic [4:0]  RST_MAX_MISSED     = 5'd15;

  // classified event passed from front to back
  typedef struct packed {
    logic [2:0]                           mode;
    logic [PKT_BYTES-1:0][7:0]            pkt;
    logic                                 hdr_ok;
    logic                                 is_stick;
    logic                                 is_fs;
    logic                                 fs_take;
    logic [SERVO_CHANNELS-1:0][15:0]      vals;
    logic [4:0]                           ridx;
    logic [7:0]                           rbyte;
  } rclbh_evt_t;

endpackage

/* hw/rtl/rclbh_if.sv */
// Channel interfaces: event input and result output.
// Depends on nothing; used by all modules of the core.
interface rclbh_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [63:0] payload_low;
  logic [15:0] payload_high;
  logic [4:0]  restore_index;
  logic [7:0]  restore_byte;
  modport source(output valid, mode, payload_low, payload_high, restore_index,
                 restore_byte, input ready);
  modport sink(input valid, mode, payload_low, payload_high, restore_index,
               restore_byte, output ready);
endinterface

interface rclbh_res_if;
  logic        valid;
  logic        ready;
  logic        tune_valid;
  logic [7:0]  rf_channel;
  logic        use_bind_address;
  logic [39:0] rx_address;
  logic [1:0]  hop_timer_command;
  logic        servo_update;
  logic [15:0] servo_zero;
  logic [15:0] servo_one;
  logic [15:0] servo_two;
  logic [1:0]  link_status;
  logic        bind_saved;
  modport source(output valid, tune_valid, rf_channel, use_bind_address, rx_address,
                 hop_timer_command, servo_update, servo_zero, servo_one, servo_two,
                 link_status, bind_saved, input ready);
  modport sink(input valid, tune_valid, rf_channel, use_bind_address, rx_address,
               hop_timer_command, servo_update, servo_zero, servo_one, servo_two,
               link_status, bind_saved, output ready);
endinterface

/* hw/rtl/rclbh_front.sv */
// Front end: accepts events, classifies packets and queues them (two entries).
// Depends on rclbh_pkg and rclbh_if.
module rclbh_front import rclbh_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  rclbh_evt_if.sink          evt,
  output logic               head_valid,
  output rclbh_evt_t         head,
  input  logic               pop
);

  rclbh_evt_t cls;
  rclbh_evt_t q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push;

  always_comb begin
    cls.mode = evt.mode;
    for (int i = 0; i < 8; i++) cls.pkt[i] = evt.payload_low[8*i +: 8];
    cls.pkt[8] = evt.payload_high[7:0];
    cls.pkt[9] = evt.payload_high[15:8];
    cls.hdr_ok   = (cls.pkt[0] == HDR_B0) && (cls.pkt[1] == HDR_B1) && (cls.pkt[2] == HDR_B2);
    cls.is_stick = (cls.pkt[7] == TAG_STICK);
    cls.is_fs    = (cls.pkt[7] == TAG_FAILSAFE);
    cls.fs_take  = (cls.pkt[8] == TAG_FS_TAKE);
    // sticks travel inverted
    for (int k = 0; k < SERVO_CHANNELS; k++)
      cls.vals[k] = ~{cls.pkt[2*k+1], cls.pkt[2*k]};
    cls.ridx  = evt.restore_index;
    cls.rbyte = evt.restore_byte;
  end

  assign evt.ready  = (cnt != 2'd2);
  assign push       = evt.valid && evt.ready;
  assign head_valid = (cnt != 2'd0);
  assign head       = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* hw/rtl/rclbh_back.sv */
// Back end: link state, binding, hopping and failsafe; one event per cycle,
// while res is not stalled, into a registered result. Depends on rclbh_pkg and rclbh_if.
module rclbh_back import rclbh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        head_valid,
  input  rclbh_evt_t  head,
  output logic        pop,
  rclbh_res_if.source res
);

  logic [15:0] failsafe_ticks, bind_ticks, servo_center;
  logic [4:0]  max_missed;

  logic                             binding, binding_n;
  logic [1:0]                       step, step_n;
  logic [15:0]                      cks, cks_n;
  logic [7:0]                       staging [STORE_BYTES];
  logic [7:0]                       staging_n [STORE_BYTES];
  logic [7:0]                       store [STORE_BYTES];
  logic [7:0]                       store_n [STORE_BYTES];
  logic [HOP_W-1:0]                 hop, hop_n;
  logic [4:0]                       miss, miss_n;
  logic [SERVO_CHANNELS-1:0][15:0]  fsv, fsv_n, servo, servo_n;
  logic [15:0]                      fc, fc_n, bc, bc_n;
  logic                             stick, stick_n;
  logic [1:0]                       status, status_n;

  logic             o_tune, o_bindaddr, o_upd, o_saved, consumed, end_bind;
  logic [1:0]       o_hop;
  logic [7:0]       o_chan;
  logic [39:0]      o_addr;
  logic [5:0]       miss_inc;
  logic [STORE_W-1:0] chan_idx;

  assign pop = head_valid && (!res.valid || res.ready);

  always_comb begin
    int bi;
    binding_n = binding;
    step_n    = step;
    cks_n     = cks;
    staging_n = staging;
    store_n   = store;
    hop_n     = hop;
    miss_n    = miss;
    fsv_n     = fsv;
    servo_n   = servo;
    fc_n      = fc;
    bc_n      = bc;
    stick_n   = stick;
    status_n  = status;
    o_tune = 1'b0; o_bindaddr = 1'b0; o_upd = 1'b0; o_saved = 1'b0;
    o_hop = HOP_NONE; consumed = 1'b0; end_bind = 1'b0;
    miss_inc = {1'b0, miss} + 6'd1;
    bi = 0;

    if (head.mode == MODE_TICK) begin
      if (fc != 16'd0) fc_n = fc - 16'd1;
      if (bc != 16'd0) bc_n = bc - 16'd1;
    end

    if (binding) begin
      if (bc_n == 16'd0) begin
        end_bind = 1'b1;
        consumed = 1'b1;
      end else if (head.mode == MODE_PACKET) begin
        consumed = 1'b1;
        if (step == 2'd0) begin
          if (head.hdr_ok) begin
            cks_n = 16'd0;
            for (int i = 0; i < ADDRESS_BYTES; i++) begin
              staging_n[i] = head.pkt[3+i];
              cks_n = cks_n + {8'd0, head.pkt[3+i]};
            end
            step_n = 2'd1;
          end
        end else if (head.pkt[0] == cks[7:0] && head.pkt[1] == cks[15:8] &&
                     head.pkt[2] == {6'd0, step - 2'd1}) begin
          for (int i = 0; i < HOP_PER_PKT; i++) begin
            bi = ADDRESS_BYTES + HOP_PER_PKT * (int'(step) - 1) + i;
            if (bi < STORE_BYTES) staging_n[bi[STORE_W-1:0]] = head.pkt[3+i];
          end
          if (step != 2'd3) begin
            step_n = step + 2'd1;
          end else begin
            step_n   = 2'd0;
            store_n  = staging_n;
            o_saved  = 1'b1;
            end_bind = 1'b1;
          end
        end
      end
    end else if (head.mode == MODE_BIND) begin
      status_n   = ST_BIND;
      binding_n  = 1'b1;
      step_n     = 2'd0;
      bc_n       = bind_ticks;
      o_tune     = 1'b1;
      o_bindaddr = 1'b1;
      consumed   = 1'b1;
    end

    if (end_bind) begin
      status_n  = ST_IDLE;
      fc_n      = failsafe_ticks;
      binding_n = 1'b0;
      hop_n     = '0;
      miss_n    = 5'd0;
      o_tune    = 1'b1;
      o_hop     = HOP_STOP;
    end

    if (head.mode == MODE_RESTORE) begin
      if (int'(head.ridx) < STORE_BYTES) store_n[STORE_W'(head.ridx)] = head.rbyte;
      if (!binding_n && !consumed) o_tune = 1'b1;
    end

    if (!binding_n) begin
      if (stick && fc_n == 16'd0) begin
        servo_n  = fsv;
        status_n = ST_FAILSAFE;
        o_upd    = 1'b1;
      end
      if (!consumed && head.mode == MODE_HOP) begin
        o_tune = 1'b1;
        if (miss_inc > {1'b0, max_missed}) begin
          // too many misses: back to hop zero
          hop_n  = '0;
          miss_n = 5'd0;
          o_hop  = HOP_STOP;
        end else begin
          miss_n = miss_inc[4:0];
          hop_n  = (hop == HOP_W'(HOP_CHANNELS - 1)) ? '0 : hop + 1'b1;
        end
      end else if (!consumed && head.mode == MODE_PACKET) begin
        miss_n = 5'd0;
        o_hop  = HOP_RESTART;
        if (head.is_stick) begin
          servo_n  = head.vals;
          o_upd    = 1'b1;
          stick_n  = 1'b1;
          fc_n     = failsafe_ticks;
          status_n = ST_RECEIVE;
        end else if (head.is_fs) begin
          if (head.fs_take) begin
            fsv_n = head.vals;
          end else begin
            for (int k = 0; k < SERVO_CHANNELS; k++) fsv_n[k] = servo_center;
            fc_n = failsafe_ticks;
          end
        end
      end
    end

    chan_idx = STORE_W'(ADDRESS_BYTES) + STORE_W'(hop_n);
    if (!o_tune)         o_chan = 8'd0;
    else if (o_bindaddr) o_chan = PAIR_CHAN;
    // a bind timeout tunes before the restored byte lands
    else if (end_bind && head.mode == MODE_RESTORE) o_chan = store[chan_idx];
    else                 o_chan = store_n[chan_idx];

    o_addr = 40'd0;
    for (int i = 0; i < ADDRESS_BYTES; i++) o_addr[8*i +: 8] = store_n[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      failsafe_ticks <= RST_FAILSAFE_TICKS;
      bind_ticks     <= RST_BIND_TICKS;
      servo_center   <= RST_SERVO_CENTER;
      max_missed     <= RST_MAX_MISSED;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FAILSAFE_TICKS: failsafe_ticks <= cfg_data;
        CFG_BIND_TICKS:     bind_ticks     <= cfg_data;
        CFG_SERVO_CENTER:   servo_center   <= cfg_data;
        CFG_MAX_MISSED:     max_missed     <= cfg_data[4:0];
        default:            max_missed     <= max_missed;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      binding <= 1'b0;
      step    <= 2'd0;
      cks     <= 16'd0;
      for (int i = 0; i < STORE_BYTES; i++) store[i] <= 8'd0;
      hop     <= '0;
      miss    <= 5'd0;
      for (int k = 0; k < SERVO_CHANNELS; k++) begin
        fsv[k]   <= RST_SERVO_CENTER;
        servo[k] <= RST_SERVO_CENTER;
      end
      fc      <= RST_FAILSAFE_TICKS;
      bc      <= 16'd0;
      stick   <= 1'b0;
      status  <= ST_IDLE;
    end else if (pop) begin
      binding <= binding_n;
      step    <= step_n;
      cks     <= cks_n;
      store   <= store_n;
      hop     <= hop_n;
      miss    <= miss_n;
      fsv     <= fsv_n;
      servo   <= servo_n;
      fc      <= fc_n;
      bc      <= bc_n;
      stick   <= stick_n;
      status  <= status_n;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) staging <= staging_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (pop) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.tune_valid        <= o_tune;
      res.rf_channel        <= o_chan;
      res.use_bind_address  <= o_bindaddr;
      res.rx_address        <= o_addr;
      res.hop_timer_command <= o_hop;
      res.servo_update      <= o_upd;
      res.servo_zero        <= servo_n[0];
      res.servo_one         <= servo_n[1];
      res.servo_two         <= servo_n[2];
      res.link_status       <= status_n;
      res.bind_saved        <= o_saved;
    end
  end

endmodule

/* hw/rtl/rc_link_bind_hop_failsafe_core.sv */
// Control core of a radio-control receiver: binding, hopping, failsafe.
// Depends on rclbh_pkg, rclbh_if, rclbh_front and rclbh_back.
//
// Channels: evt takes one event per item (tick, hop expiry, packet, bind
// request, restore of one bind byte); res returns exactly one result item
// per event, in order. Both use valid/ready; an item moves when both are high.
// The cfg port (cfg_we, cfg_index, cfg_data) writes one register per cycle;
// the user must use it only while no event is in flight (the core does not enforce this).
// An accepted event enters a two-entry queue and is executed once it is at
// the head and the result register is free; its result is then registered
// and held valid until res takes it.
// Throughput: one event per cycle while res is not stalled, set by the
// execute stage in the back end that updates all link state at once.
// Reset (rst, synchronous) empties the queue, drops any pending result,
// clears the bind store and restores register defaults.
// When the receiver stalls, the result register holds, the queue fills
// with up to two events, and evt.ready then drops until res drains.
module rc_link_bind_hop_failsafe_core import rclbh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  rclbh_evt_if.sink   evt,
  rclbh_res_if.source res
);

  logic       head_valid;
  rclbh_evt_t head;
  logic       pop;

  rclbh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .evt        (evt),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  rclbh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res        (res)
  );

`ifndef SYNTHESIS
  a_bind_tune: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.use_bind_address |-> res.tune_valid && res.rf_channel == PAIR_CHAN)
    else $error("bind address without bind channel tune");

  a_saved_stop: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.bind_saved |-> res.hop_timer_command == HOP_STOP &&
                                    res.link_status == ST_IDLE)
    else $error("completed bind without hop stop and idle status");

  a_bind_no_servo: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.link_status == ST_BIND |-> !res.servo_update)
    else $error("servo update while binding");
`endif

endmodule
